/* src/itoa_pkg.sv */
// Shared types, codes and character helpers for the integer to ASCII formatter.
// Used by itoa_front, itoa_back and the top level; depends on nothing else.
`default_nettype none

package itoa_pkg;

  typedef enum logic [1:0] {
    MODE_HEX_LOWER = 2'd0,
    MODE_HEX_UPPER = 2'd1,
    MODE_POINTER   = 2'd2,
    MODE_DECIMAL   = 2'd3
  } mode_e;

  typedef struct packed {
    logic upper;
    logic prefix;
    logic decimal;
  } ctl_t;

  localparam int CTL_W      = 3;
  localparam int DEC_BITS   = 32;
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W      = BCD_DIGITS * 4;

  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_X       = 8'h78;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [3:0] DIGIT_TEN    = 4'd10;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < DIGIT_TEN) begin
      c = CHAR_ZERO + {4'h0, d};
    end else if (upper) begin
      c = CHAR_UPPER_A + {4'h0, d - DIGIT_TEN};
    end else begin
      c = CHAR_LOWER_A + {4'h0, d - DIGIT_TEN};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* src/itoa_fifo.sv */
// Two-entry queue that decouples the classifying front from the formatting back.
// Stand-alone; carries an opaque word of DATA_W bits.
`default_nettype none

module itoa_fifo #(
  parameter int DATA_W = 67
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   full,
  input  wire logic              pop,
  output logic                   not_empty,
  output logic [DATA_W-1:0]      pop_data
);

  logic [DATA_W-1:0] mem_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/itoa_front.sv */
// Input stage: takes a beat, masks the value and decodes the mode into control flags.
// Depends on itoa_pkg; feeds itoa_fifo.
`default_nettype none

module itoa_front #(
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [1:0]             in_mode,
  input  wire logic [63:0]            in_value,
  output logic                        push,
  output itoa_pkg::ctl_t              push_ctl,
  output logic [VALUE_WIDTH-1:0]      push_value,
  input  wire logic                   fifo_full
);

  logic                   valid_r;
  itoa_pkg::ctl_t         ctl_r;
  logic [VALUE_WIDTH-1:0] value_r;
  logic                   accept;

  assign in_stall   = valid_r && fifo_full;
  assign accept     = in_valid && !in_stall;
  assign push       = valid_r && !fifo_full;
  assign push_ctl   = ctl_r;
  assign push_value = value_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      value_r       <= in_value[VALUE_WIDTH-1:0];
      ctl_r.upper   <= (in_mode == itoa_pkg::MODE_HEX_UPPER);
      ctl_r.prefix  <= (in_mode == itoa_pkg::MODE_POINTER);
      ctl_r.decimal <= (in_mode == itoa_pkg::MODE_DECIMAL);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (push) begin
      valid_r <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* src/itoa_back.sv */
// Formatting engine: binary to BCD by shift-and-add-3, leading zero scan, and
// character output through a registered result stage. Depends on itoa_pkg.
`default_nettype none

module itoa_back #(
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   fifo_not_empty,
  input  wire itoa_pkg::ctl_t         fifo_ctl,
  input  wire logic [VALUE_WIDTH-1:0] fifo_value,
  output logic                        pop,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [7:0]                  out_char,
  output logic                        out_last
);

  localparam int HEX_W = ((VALUE_WIDTH + 3) / 4) * 4;
  localparam int DW    = (HEX_W > itoa_pkg::BCD_W) ? HEX_W : itoa_pkg::BCD_W;
  localparam int ND    = DW / 4;
  localparam int RW    = $clog2(ND + 1);
  localparam int CW    = $clog2(itoa_pkg::DEC_BITS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_PFX0,
    S_PFX1,
    S_EMIT
  } state_t;

  state_t                        state_r;
  itoa_pkg::ctl_t                ctl_r;
  logic [DW-1:0]                 dig_r;
  logic [itoa_pkg::DEC_BITS-1:0] bin_r;
  logic [CW-1:0]                 cnt_r;
  logic [RW-1:0]                 rem_r;
  logic                          out_valid_r;
  logic [7:0]                    out_char_r;
  logic                          out_last_r;

  logic                          out_free;
  logic [DW-1:0]                 ext_value;
  logic [itoa_pkg::BCD_W-1:0]    bcd_adj;
  logic [3:0]                    top_nib;

  assign out_free  = !out_valid_r || !out_stall;
  assign pop       = (state_r == S_IDLE) && fifo_not_empty;
  assign ext_value = DW'(fifo_value);
  assign top_nib   = dig_r[DW-1 -: 4];
  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  always_comb begin
    for (int i = 0; i < itoa_pkg::BCD_DIGITS; i++) begin
      if (dig_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = dig_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = dig_r[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ctl_r       <= '0;
      dig_r       <= '0;
      bin_r       <= '0;
      cnt_r       <= '0;
      rem_r       <= '0;
      out_char_r  <= '0;
      out_last_r  <= 1'b0;
    end else begin
      if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (fifo_not_empty) begin
            ctl_r <= fifo_ctl;
            rem_r <= RW'(ND);
            cnt_r <= '0;
            if (fifo_ctl.decimal) begin
              bin_r   <= ext_value[itoa_pkg::DEC_BITS-1:0];
              dig_r   <= '0;
              state_r <= S_CONV;
            end else begin
              dig_r   <= ext_value;
              state_r <= S_SKIP;
            end
          end
        end
        S_CONV: begin
          dig_r <= DW'({bcd_adj[itoa_pkg::BCD_W-2:0], bin_r[itoa_pkg::DEC_BITS-1]});
          bin_r <= {bin_r[itoa_pkg::DEC_BITS-2:0], 1'b0};
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(itoa_pkg::DEC_BITS - 1)) begin
            state_r <= S_SKIP;
          end
        end
        S_SKIP: begin
          if ((top_nib == 4'd0) && (rem_r != RW'(1))) begin
            dig_r <= {dig_r[DW-5:0], 4'h0};
            rem_r <= rem_r - RW'(1);
          end else if (ctl_r.prefix) begin
            state_r <= S_PFX0;
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_PFX0: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_char_r  <= itoa_pkg::CHAR_ZERO;
            out_last_r  <= 1'b0;
            state_r     <= S_PFX1;
          end
        end
        S_PFX1: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_char_r  <= itoa_pkg::CHAR_X;
            out_last_r  <= 1'b0;
            state_r     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_char_r  <= itoa_pkg::digit_char(top_nib, ctl_r.upper);
            out_last_r  <= (rem_r == RW'(1));
            dig_r       <= {dig_r[DW-5:0], 4'h0};
            rem_r       <= rem_r - RW'(1);
            if (rem_r == RW'(1)) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/integer_to_ascii_formatter.sv */
// Top level of the integer to ASCII formatter.
// Instantiates itoa_front, itoa_fifo and itoa_back; depends on itoa_pkg.
//
// Each input beat carries a mode and a number, and the block returns the
// number's text one character per output beat, most significant digit first,
// with out_last set on the final character. Modes are lowercase hex, uppercase
// hex, pointer ("0x" then lowercase hex) and unsigned decimal of the low 32
// bits; leading zeros are dropped and zero prints as "0". Only the low
// VALUE_WIDTH bits of in_value are used. An input stage and a two-entry queue
// take up to three items ahead of the formatter, which handles one number at
// a time. With N = ceil(max(VALUE_WIDTH, 40) / 4) digit slots, it takes each
// number through its steps in order: for decimal, the one-bit-per-cycle binary
// to BCD conversion; then the one-digit-per-cycle leading zero scan over up to
// N - 1 zero digits; then the "0x" prefix in pointer mode; then the digits. A
// stalled output holds the prefix and the digits.
`default_nettype none

module integer_to_ascii_formatter #(
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic [63:0] in_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_char,
  output logic             out_last
);

  localparam int Q_W = itoa_pkg::CTL_W + VALUE_WIDTH;

  logic                   push;
  itoa_pkg::ctl_t         push_ctl;
  logic [VALUE_WIDTH-1:0] push_value;
  logic                   fifo_full;
  logic                   pop;
  logic                   fifo_not_empty;
  logic [Q_W-1:0]         pop_data;
  itoa_pkg::ctl_t         pop_ctl;
  logic [VALUE_WIDTH-1:0] pop_value;

  assign pop_ctl   = itoa_pkg::ctl_t'(pop_data[Q_W-1 -: itoa_pkg::CTL_W]);
  assign pop_value = pop_data[VALUE_WIDTH-1:0];

  itoa_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_mode   (in_mode),
    .in_value  (in_value),
    .push      (push),
    .push_ctl  (push_ctl),
    .push_value(push_value),
    .fifo_full (fifo_full)
  );

  itoa_fifo #(
    .DATA_W(Q_W)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data({push_ctl, push_value}),
    .full     (fifo_full),
    .pop      (pop),
    .not_empty(fifo_not_empty),
    .pop_data (pop_data)
  );

  itoa_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .fifo_not_empty(fifo_not_empty),
    .fifo_ctl      (pop_ctl),
    .fifo_value    (pop_value),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char      (out_char),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire
